// ===== hdl/tga_rle_decoder_defines.svh =====
// Assertion macros used by the TGA run-length decoder RTL.
// Include this header with the bare file name; it has no dependencies.
`ifndef TGA_RLE_DECODER_DEFINES_SVH
`define TGA_RLE_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trd assertion failed");

`endif

// ===== hdl/trd_pkg.sv =====
// Package for the TGA run-length decoder: payload structs, control types and constants.
// Used by trd_ctrl, trd_datapath and tga_rle_decoder; depends on nothing.
package trd_pkg;

   localparam int unsigned PIX_CNT_W = 25;
   localparam int unsigned BPP_W     = 3;
   localparam int unsigned CSR_W     = 25;

   localparam logic [PIX_CNT_W-1:0] MAX_PIXELS          = 25'h100_0000;
   localparam logic [BPP_W-1:0]     MAX_BYTES_PER_PIXEL = 3'd4;
   localparam logic [BPP_W-1:0]     BPP_RESET           = 3'd3;
   localparam logic [PIX_CNT_W-1:0] IMAGE_RESET         = 25'd1;
   localparam logic [7:0]           RAW_LIMIT           = 8'd128;
   localparam logic [7:0]           RUN_BASE            = 8'd127;

   typedef enum logic {
      CSR_BYTES_PER_PIXEL = 1'b0,
      CSR_IMAGE_PIXELS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_first;
      logic [31:0] pixel_second;
      logic [1:0]  pixel_count;
      logic        run_end;
      logic        image_end;
      logic        overrun_error;
   } rsp_type;

   typedef enum logic {
      ST_ACCEPT,
      ST_RUN
   } state_type;

   typedef enum logic {
      PH_HEADER,
      PH_PIXEL
   } phase_type;

   typedef struct packed {
      logic take_byte;
      logic emit_run;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic run_pixel_done;
      logic run_last;
   } status_type;

endpackage

// ===== hdl/trd_ctrl.sv =====
// Controller state machine of the TGA run-length decoder.
// Depends on trd_pkg; drives the datapath through cmd_type and reads status_type.
module trd_ctrl
   import trd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      cmd.take_byte = 1'b0;
      cmd.emit_run  = 1'b0;
      case (state_ff)
         ST_ACCEPT: begin
            // A byte can only be taken when the output register has room for its result.
            req_stall     = !status.out_free;
            cmd.take_byte = req_valid && status.out_free;
            if (cmd.take_byte && status.run_pixel_done) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.emit_run = status.out_free;
            if (cmd.emit_run && status.run_last) begin
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

endmodule

// ===== hdl/trd_datapath.sv =====
// Datapath of the TGA run-length decoder: configuration, packet state, pixel
// assembly and the result register. Depends on trd_pkg and tga_rle_decoder_defines.svh.
`include "tga_rle_decoder_defines.svh"
module trd_datapath
   import trd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  cmd_type              cmd,
   output status_type           status
);

   logic [BPP_W-1:0]     bpp_ff, bpp_in;
   logic [PIX_CNT_W-1:0] image_ff, image_in;
   phase_type            phase_ff, phase_in;
   logic [7:0]           packet_left_ff, packet_left_in;
   logic                 is_run_ff, is_run_in;
   logic [1:0]           byte_index_ff, byte_index_in;
   logic [31:0]          pixel_accum_ff, pixel_accum_in;
   logic [PIX_CNT_W-1:0] pixels_done_ff, pixels_done_in;
   logic                 halted_ff, halted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // State as seen by the current byte, after a frame start has cleared it.
   phase_type            phase_e;
   logic [7:0]           packet_left_e;
   logic                 is_run_e;
   logic [1:0]           byte_index_e;
   logic [31:0]          pixel_accum_e;
   logic [PIX_CNT_W-1:0] pixels_done_e;
   logic                 halted_e;

   logic [PIX_CNT_W-1:0] total;
   logic [BPP_W-1:0]     bpp_eff;
   logic                 ignore;
   logic [7:0]           pkt_len;
   logic                 overrun;
   logic [31:0]          accum_new;
   logic [1:0]           index_inc;
   logic                 complete;
   logic [7:0]           raw_left;
   logic [1:0]           run_cnt;
   logic [7:0]           run_left;
   logic [PIX_CNT_W-1:0] run_done;
   logic                 out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff         <= BPP_RESET;
         image_ff       <= IMAGE_RESET;
         phase_ff       <= PH_HEADER;
         packet_left_ff <= '0;
         is_run_ff      <= 1'b0;
         byte_index_ff  <= '0;
         pixel_accum_ff <= '0;
         pixels_done_ff <= '0;
         halted_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         bpp_ff         <= bpp_in;
         image_ff       <= image_in;
         phase_ff       <= phase_in;
         packet_left_ff <= packet_left_in;
         is_run_ff      <= is_run_in;
         byte_index_ff  <= byte_index_in;
         pixel_accum_ff <= pixel_accum_in;
         pixels_done_ff <= pixels_done_in;
         halted_ff      <= halted_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      bpp_in   = bpp_ff;
      image_in = image_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_BYTES_PER_PIXEL: bpp_in   = csr_wdata[BPP_W-1:0];
            CSR_IMAGE_PIXELS:    image_in = csr_wdata[PIX_CNT_W-1:0];
            default: begin
               bpp_in = bpp_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (req_data.frame_start) begin
         phase_e       = PH_HEADER;
         packet_left_e = '0;
         is_run_e      = 1'b0;
         byte_index_e  = '0;
         pixel_accum_e = '0;
         pixels_done_e = '0;
         halted_e      = 1'b0;
      end else begin
         phase_e       = phase_ff;
         packet_left_e = packet_left_ff;
         is_run_e      = is_run_ff;
         byte_index_e  = byte_index_ff;
         pixel_accum_e = pixel_accum_ff;
         pixels_done_e = pixels_done_ff;
         halted_e      = halted_ff;
      end

      total = (image_ff > MAX_PIXELS) ? MAX_PIXELS : image_ff;
      if (bpp_ff == '0) begin
         bpp_eff = BPP_W'(1);
      end else if (bpp_ff > MAX_BYTES_PER_PIXEL) begin
         bpp_eff = MAX_BYTES_PER_PIXEL;
      end else begin
         bpp_eff = bpp_ff;
      end

      ignore  = halted_e || (pixels_done_e >= total);
      pkt_len = (req_data.data_byte < RAW_LIMIT) ? req_data.data_byte + 8'd1
                                                 : req_data.data_byte - RUN_BASE;
      overrun = ({1'b0, pixels_done_e} + (PIX_CNT_W+1)'(pkt_len)) > {1'b0, total};

      accum_new = pixel_accum_e | (32'(req_data.data_byte) << {byte_index_e, 3'b000});
      index_inc = byte_index_e + 2'd1;
      complete  = (index_inc == 2'd0) || ({1'b0, index_inc} >= bpp_eff);
      raw_left  = (packet_left_e != '0) ? packet_left_e - 8'd1 : 8'd0;

      run_cnt  = (packet_left_ff >= 8'd2) ? 2'd2 : 2'd1;
      run_left = packet_left_ff - {6'b0, run_cnt};
      run_done = pixels_done_ff + PIX_CNT_W'(run_cnt);

      status.out_free       = !rsp_valid_ff || !rsp_stall;
      status.run_pixel_done = !ignore && (phase_e == PH_PIXEL) && is_run_e && complete;
      status.run_last       = packet_left_ff <= 8'd2;

      phase_in       = phase_ff;
      packet_left_in = packet_left_ff;
      is_run_in      = is_run_ff;
      byte_index_in  = byte_index_ff;
      pixel_accum_in = pixel_accum_ff;
      pixels_done_in = pixels_done_ff;
      halted_in      = halted_ff;
      out_load       = 1'b0;
      rsp_data_in    = rsp_data_ff;

      if (cmd.take_byte) begin
         phase_in       = phase_e;
         packet_left_in = packet_left_e;
         is_run_in      = is_run_e;
         byte_index_in  = byte_index_e;
         pixel_accum_in = pixel_accum_e;
         pixels_done_in = pixels_done_e;
         halted_in      = halted_e;
         if (!ignore) begin
            if (phase_e == PH_HEADER) begin
               if (overrun) begin
                  halted_in   = 1'b1;
                  out_load    = 1'b1;
                  rsp_data_in = '{pixel_first: '0, pixel_second: '0, pixel_count: 2'd0,
                                  run_end: 1'b1, image_end: 1'b0, overrun_error: 1'b1};
               end else begin
                  packet_left_in = pkt_len;
                  is_run_in      = !(req_data.data_byte < RAW_LIMIT);
                  byte_index_in  = '0;
                  pixel_accum_in = '0;
                  phase_in       = PH_PIXEL;
               end
            end else if (!complete) begin
               byte_index_in  = index_inc;
               pixel_accum_in = accum_new;
            end else if (!is_run_e) begin
               byte_index_in  = '0;
               pixel_accum_in = '0;
               pixels_done_in = pixels_done_e + PIX_CNT_W'(1);
               packet_left_in = raw_left;
               if (raw_left == '0) begin
                  phase_in = PH_HEADER;
               end
               out_load    = 1'b1;
               rsp_data_in = '{pixel_first: accum_new, pixel_second: '0, pixel_count: 2'd1,
                               run_end: 1'b1,
                               image_end: (pixels_done_e + PIX_CNT_W'(1)) == total,
                               overrun_error: 1'b0};
            end else begin
               // The run pixel stays in the accumulator while its copies go out.
               byte_index_in  = '0;
               pixel_accum_in = accum_new;
            end
         end
      end else if (cmd.emit_run) begin
         packet_left_in = run_left;
         pixels_done_in = run_done;
         if (run_left == '0) begin
            phase_in       = PH_HEADER;
            pixel_accum_in = '0;
         end
         out_load    = 1'b1;
         rsp_data_in = '{pixel_first: pixel_accum_ff,
                         pixel_second: (run_cnt == 2'd2) ? pixel_accum_ff : 32'd0,
                         pixel_count: run_cnt, run_end: run_left == '0,
                         image_end: run_done == total, overrun_error: 1'b0};
      end

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TRD_ASSERT_SAME(a_cmd_exclusive, clock, reset, cmd.emit_run, !cmd.take_byte)
   `TRD_ASSERT_SAME(a_run_has_work, clock, reset, cmd.emit_run,
      (phase_ff == PH_PIXEL) && is_run_ff && (packet_left_ff != '0))
   `TRD_ASSERT_NEXT(a_error_halts, clock, reset,
      out_load && rsp_data_in.overrun_error, halted_ff && rsp_valid_ff)
   `TRD_ASSERT_SAME(a_empty_is_error, clock, reset,
      out_load && (rsp_data_in.pixel_count == 2'd0), rsp_data_in.overrun_error)

endmodule

// ===== hdl/tga_rle_decoder.sv =====
// Top level of the TGA run-length decoder: joins the controller and the datapath.
// Depends on trd_pkg, trd_ctrl and trd_datapath.
//
//   port group  direction  payload    transfer when
//   req_        in         req_type   req_valid high, req_stall low
//   rsp_        out        rsp_type   rsp_valid high, rsp_stall low
//   csr_        in         25 bits    csr_write high
//
// A raw pixel's result is loaded into the output register by the edge that takes its
// last byte. The byte that completes the pixel of an n-pixel run starts the run
// sequencer, which sends ceil(n/2) results of up to two pixels each through the single
// output register while req_stall stays high.
// A held result stalls the input.
// Synchronous reset loads bytes_per_pixel 3 and image_pixels 1 and clears all state but the result payload register.
module tga_rle_decoder
   import trd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   trd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   trd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for tga_rle_decoder: a directed table, then random frames.
// A local decoder model predicts the results of all but the typed table rows. Needs trd_pkg and the decoder RTL.
module tb_top;
   import trd_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 75;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PLAN_ROWS     = 25;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type result;
   } stream_item_type;

   typedef struct packed {
      logic                 cfg;
      logic [BPP_W-1:0]     bpp;
      logic [PIX_CNT_W-1:0] pixels;
      logic [7:0]           data_byte;
      logic                 frame_start;
      logic                 typed;
      rsp_type              result;
   } plan_row_type;

   localparam rsp_type NO_RSP  = '0;
   localparam rsp_type ERR_RSP = '{32'h0, 32'h0, 2'd0, 1'b1, 1'b0, 1'b1};

   // Rows with cfg set reprogram both registers once the block is idle.
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{1'b0, 3'd0, 25'd0, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'hFF, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'hAA, 1'b0, 1'b1,
        '{32'h00AA00FF, 32'h0, 2'd1, 1'b1, 1'b1, 1'b0}},
      '{1'b0, 3'd0, 25'd0, 8'h55, 1'b0, 1'b0, NO_RSP},
      '{1'b1, 3'd1, 25'd4, 8'hFF, 1'b1, 1'b1, ERR_RSP},
      '{1'b0, 3'd0, 25'd0, 8'h12, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'h83, 1'b1, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'hFF, 1'b0, 1'b0, NO_RSP},
      '{1'b1, 3'd4, 25'h1FF_FFFF, 8'h80, 1'b1, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'hFF, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'hFF, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'hFF, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'hFF, 1'b0, 1'b1,
        '{32'hFFFFFFFF, 32'h0, 2'd1, 1'b1, 1'b0, 1'b0}},
      '{1'b1, 3'd0, 25'd0, 8'h00, 1'b1, 1'b0, NO_RSP},
      '{1'b1, 3'd7, 25'd2, 8'h81, 1'b1, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'h01, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'h80, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'h7F, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'hFE, 1'b0, 1'b0, NO_RSP},
      '{1'b1, 3'd2, 25'd3, 8'h02, 1'b1, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'hAB, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'h80, 1'b1, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'h01, 1'b0, 1'b0, NO_RSP},
      '{1'b0, 3'd0, 25'd0, 8'h02, 1'b0, 1'b0, NO_RSP}
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_write = 1'b0;
   csr_index_type    csr_index = CSR_BYTES_PER_PIXEL;
   logic [CSR_W-1:0] csr_wdata = '0;

   // Decoder model state and its copy of the registers.
   logic [BPP_W-1:0]     bpp_reg;
   logic [PIX_CNT_W-1:0] image_reg;
   phase_type            phase_q;
   logic [7:0]           left_q;
   logic                 run_q;
   logic [1:0]           idx_q;
   logic [31:0]          acc_q;
   logic [PIX_CNT_W-1:0] done_q;
   logic                 halted_q;

   rsp_type         step_results[$];
   rsp_type         decoded_queue[$];
   stream_item_type stream_queue[$];

   int             errors          = 0;
   int             useful_items    = 0;
   int             results_checked = 0;
   int             frame_count     = 0;
   int             burst_left      = 1;
   int             gap_left        = 0;
   int             hold_left       = 0;
   int             mode_left       = 0;
   int             quiet_cycles    = 0;
   bit             hold_request    = 1'b0;
   stall_mode_type stall_mode      = STALL_NONE;
   stream_item_type sent_item;
   rsp_type        want;
   logic           sent;
   logic           skipped;

   always #HALF_PERIOD clock = ~clock;

   tga_rle_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic logic [BPP_W-1:0] pixel_bytes(logic [BPP_W-1:0] bpp);
      if (bpp == '0) return 3'd1;
      if (bpp > MAX_BYTES_PER_PIXEL) return MAX_BYTES_PER_PIXEL;
      return bpp;
   endfunction

   function automatic logic [PIX_CNT_W-1:0] image_limit(logic [PIX_CNT_W-1:0] pix);
      return (pix > MAX_PIXELS) ? MAX_PIXELS : pix;
   endfunction

   task automatic clear_decoder();
      phase_q  = PH_HEADER;
      left_q   = '0;
      run_q    = 1'b0;
      idx_q    = '0;
      acc_q    = '0;
      done_q   = '0;
      halted_q = 1'b0;
   endtask

   // Works out the results one stream byte causes; skip is set for ignored bytes.
   task automatic decode_byte(input req_type r, output logic skip);
      logic [PIX_CNT_W-1:0] total;
      logic [7:0]           n;
      logic [31:0]          px;
      logic [1:0]           cnt;
      rsp_type              res;
      step_results.delete();
      skip = 1'b0;
      if (r.frame_start) clear_decoder();
      total = image_limit(image_reg);
      if (halted_q || done_q >= total) begin
         skip = 1'b1;
         return;
      end
      if (phase_q == PH_HEADER) begin
         n = (r.data_byte < RAW_LIMIT) ? r.data_byte + 8'd1 : r.data_byte - RUN_BASE;
         if (({1'b0, done_q} + 26'(n)) > {1'b0, total}) begin
            halted_q = 1'b1;
            step_results.push_back(ERR_RSP);
            return;
         end
         left_q  = n;
         run_q   = (r.data_byte >= RAW_LIMIT);
         idx_q   = '0;
         acc_q   = '0;
         phase_q = PH_PIXEL;
         return;
      end
      acc_q = acc_q | (32'(r.data_byte) << (8 * idx_q));
      idx_q = idx_q + 2'd1;
      if (idx_q != 2'd0 && {1'b0, idx_q} < pixel_bytes(bpp_reg)) return;
      px    = acc_q;
      idx_q = '0;
      acc_q = '0;
      if (!run_q) begin
         done_q = done_q + 1'b1;
         if (left_q != 0) left_q = left_q - 8'd1;
         if (left_q == 0) phase_q = PH_HEADER;
         res = '{px, 32'h0, 2'd1, 1'b1, done_q == total, 1'b0};
         step_results.push_back(res);
         return;
      end
      while (left_q != 0) begin
         cnt    = (left_q >= 8'd2) ? 2'd2 : 2'd1;
         left_q = left_q - 8'(cnt);
         done_q = done_q + PIX_CNT_W'(cnt);
         res    = '{px, (cnt == 2'd2) ? px : 32'h0, cnt, left_q == 0, done_q == total, 1'b0};
         step_results.push_back(res);
      end
      phase_q = PH_HEADER;
   endtask

   // Sender: offers queued bytes in bursts, tracks the registers and runs the model
   // on every accepted byte.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         bpp_reg   = BPP_RESET;
         image_reg = IMAGE_RESET;
         clear_decoder();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_BYTES_PER_PIXEL) bpp_reg = csr_wdata[BPP_W-1:0];
            else image_reg = csr_wdata[PIX_CNT_W-1:0];
         end
         sent = req_valid && !req_stall;
         if (sent) begin
            sent_item = stream_queue.pop_front();
            decode_byte(sent_item.req, skipped);
            if (!skipped) useful_items++;
            if (sent_item.typed) decoded_queue.push_back(sent_item.result);
            else foreach (step_results[i]) decoded_queue.push_back(step_results[i]);
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left   = $urandom_range(0, 6);
            end
         end
         // A stalled transfer keeps its valid and payload.
         if (!req_valid || sent) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (stream_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= stream_queue[0].req;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern of its own, plus one long hold on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
            errors++;
         end else begin
            want = decoded_queue.pop_front();
            results_checked++;
            check_field("pixel_first", want.pixel_first, rsp_data.pixel_first);
            check_field("pixel_second", want.pixel_second, rsp_data.pixel_second);
            check_field("pixel_count", 32'(want.pixel_count), 32'(rsp_data.pixel_count));
            check_field("run_end", 32'(want.run_end), 32'(rsp_data.run_end));
            check_field("image_end", 32'(want.image_end), 32'(rsp_data.image_end));
            check_field("overrun_error", 32'(want.overrun_error),
                        32'(rsp_data.overrun_error));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tga_rle_decoder test failed");
            $finish;
         end
      end
   end

   task automatic queue_byte(logic [7:0] value, logic fs);
      stream_item_type entry;
      entry = '{'{value, fs}, 1'b0, NO_RSP};
      stream_queue.push_back(entry);
   endtask

   // Returns once every queued byte has gone and every predicted result has arrived.
   task automatic wait_idle();
      while (stream_queue.size() != 0 || req_valid || decoded_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // One frame: new settings, then mostly well-formed packets with random content.
   // Some frames end in an overrun packet or are cut off in the middle of a packet.
   // The hold frame keeps its stream whole so that bytes pile up behind the held result.
   task automatic random_frame(bit hold);
      logic [BPP_W-1:0]     bpp;
      logic [PIX_CNT_W-1:0] pix;
      logic [CSR_W-1:0]     wdata;
      logic                 fs;
      bit                   alive;
      bit                   run;
      int                   roll;
      int                   eb;
      int                   left;
      int                   n;
      int                   count;
      int                   budget;
      wait_idle();
      roll = $urandom_range(0, 9);
      bpp  = (roll < 8) ? BPP_W'($urandom_range(1, 4)) : BPP_W'($urandom_range(0, 7));
      roll = $urandom_range(0, 9);
      case (roll)
         7:       pix = PIX_CNT_W'($urandom_range(49, 300));
         8:       pix = PIX_CNT_W'($urandom);
         9: begin
            case ($urandom_range(0, 3))
               0:       pix = '0;
               1:       pix = MAX_PIXELS;
               2:       pix = '1;
               default: pix = 25'd1;
            endcase
         end
         default: pix = PIX_CNT_W'($urandom_range(1, 48));
      endcase
      if (hold) begin
         bpp = 3'd1;
         pix = PIX_CNT_W'($urandom_range(49, 300));
      end
      wdata            = CSR_W'($urandom);
      wdata[BPP_W-1:0] = bpp;
      write_reg(CSR_BYTES_PER_PIXEL, wdata);
      write_reg(CSR_IMAGE_PIXELS, pix);
      if (hold) hold_request = 1'b1;
      eb     = int'(pixel_bytes(bpp));
      left   = int'(image_limit(pix));
      budget = $urandom_range(20, 60);
      fs     = 1'b1;
      alive  = 1'b1;
      while (alive && left > 0 && budget > 0) begin
         roll = $urandom_range(0, 19);
         if (roll == 0 && left < 128 && !hold) begin
            n = $urandom_range(left + 1, 128);
            queue_byte($urandom_range(0, 1) ? 8'(n + 127) : 8'(n - 1), fs);
            alive = 1'b0;
         end else begin
            run = $urandom_range(0, 1);
            if (run) n = $urandom_range(1, (left < 128) ? left : 128);
            else if (roll == 1 && eb <= 2) n = (left < 128) ? left : 128;
            else n = $urandom_range(1, (left < 4) ? left : 4);
            queue_byte(run ? 8'(n + 127) : 8'(n - 1), fs);
            fs    = 1'b0;
            count = run ? eb : n * eb;
            for (int k = 0; k < count && alive; k++) begin
               if (!hold && $urandom_range(0, 59) == 0) alive = 1'b0;
               else queue_byte(8'($urandom), 1'b0);
            end
            left   = left - n;
            budget = budget - count - 1;
         end
      end
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0);
   endtask

   initial begin
      plan_row_type    row;
      stream_item_type entry;
      int              base;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PLAN[i]) begin
         row = DIRECTED_PLAN[i];
         if (row.cfg) begin
            wait_idle();
            write_reg(CSR_BYTES_PER_PIXEL, CSR_W'(row.bpp));
            write_reg(CSR_IMAGE_PIXELS, row.pixels);
         end
         entry = '{'{row.data_byte, row.frame_start}, row.typed, row.result};
         stream_queue.push_back(entry);
      end
      wait_idle();

      // The second frame is the hold frame, so at least two frames always run.
      base = useful_items;
      while (useful_items - base < RANDOM_ITEMS || frame_count < 2) begin
         random_frame(frame_count == 1);
         frame_count++;
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (decoded_queue.size() != 0) begin
         $display("%0t: %0d predicted results never arrived", $time, decoded_queue.size());
         errors += decoded_queue.size();
      end
      $display("Ran %0d table rows and %0d random frames at mixed pixel and image sizes.",
               PLAN_ROWS, frame_count);
      $display("Decoded %0d bytes and compared %0d results; %0d mismatches.",
               useful_items, results_checked, errors);
      if (errors == 0) begin
         $display("tga_rle_decoder test passed");
      end else begin
         $display("tga_rle_decoder test failed");
      end
      $finish;
   end

endmodule
